// ----- sv/lpmd_pkg.sv -----
// Package for the length-prefixed message deframer.
// Holds the word types, parse phase and byte kind codes shared by every module.
// No dependencies.
package lpmd_pkg;

  localparam int unsigned LEN_BYTES = 4;
  localparam int unsigned LEN_WIDTH = 8 * LEN_BYTES;
  localparam int unsigned CNT_WIDTH = $clog2(LEN_BYTES);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_KEYLEN = 3'd1,
    PH_KEY    = 3'd2,
    PH_VALLEN = 3'd3,
    PH_VALUE  = 3'd4,
    PH_TRAIL  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_LEN   = 3'd0,
    KIND_HDR   = 3'd1,
    KIND_KEY   = 3'd2,
    KIND_VALUE = 3'd3,
    KIND_TRAIL = 3'd4
  } kind_t;

  typedef enum logic {
    MODE_REQUEST  = 1'b0,
    MODE_RESPONSE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } in_word_t;

  typedef struct packed {
    kind_t      byte_kind;
    logic [7:0] byte_out;
    logic       message_done;
    logic       message_ok;
  } out_word_t;

endpackage

// ----- sv/lpmd_in_stage.sv -----
// Input register stage of the deframer.
// Captures one incoming word per cycle while not stalled and holds it until the parser takes it.
// Depends on lpmd_pkg.
module lpmd_in_stage import lpmd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output logic     held_valid,
  output in_word_t held_word,
  input  logic     take
);

  logic     valid;
  in_word_t word;

  // The stage can load whenever it is empty or its word leaves this cycle.
  assign in_stall   = valid && !take;
  assign held_valid = valid;
  assign held_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      word <= in_word;
    end
  end

endmodule

// ----- sv/lpmd_parser.sv -----
// Parse state and byte classification for the deframer.
// Tags one held word per fire and advances the phase, length and count state.
// Depends on lpmd_pkg.
module lpmd_parser import lpmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  input  logic      fire,
  input  in_word_t  word,
  output out_word_t result
);

  mode_t                 format_mode;
  phase_t                phase;
  phase_t                phase_next;
  logic [CNT_WIDTH-1:0]  count;
  logic [CNT_WIDTH-1:0]  count_next;
  logic [LEN_WIDTH-1:0]  acc;
  logic [LEN_WIDTH-1:0]  acc_next;
  logic [LEN_WIDTH-1:0]  rem;
  logic [LEN_WIDTH-1:0]  rem_next;
  logic [LEN_WIDTH-1:0]  acc_shift;
  logic [LEN_WIDTH-1:0]  rem_dec;
  logic                  len_done;
  kind_t                 kind;

  assign acc_shift = {acc[LEN_WIDTH-9:0], word.msg_byte};
  assign rem_dec   = rem - LEN_WIDTH'(1);
  assign len_done  = (count == CNT_WIDTH'(LEN_BYTES - 1));

  always_comb begin
    phase_next = phase;
    count_next = count;
    acc_next   = acc;
    rem_next   = rem;
    kind       = KIND_TRAIL;
    unique case (phase)
      PH_HEADER: begin
        kind       = KIND_HDR;
        count_next = '0;
        acc_next   = '0;
        phase_next = (format_mode == MODE_REQUEST) ? PH_KEYLEN : PH_VALLEN;
      end
      PH_KEYLEN, PH_VALLEN: begin
        kind     = KIND_LEN;
        acc_next = acc_shift;
        if (len_done) begin
          count_next = '0;
          rem_next   = acc_shift;
          acc_next   = '0;
          if (phase == PH_KEYLEN) begin
            phase_next = (acc_shift == '0) ? PH_VALLEN : PH_KEY;
          end else begin
            phase_next = (acc_shift == '0) ? PH_TRAIL : PH_VALUE;
          end
        end else begin
          count_next = count + CNT_WIDTH'(1);
        end
      end
      PH_KEY: begin
        kind     = KIND_KEY;
        rem_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_VALLEN;
        end
      end
      PH_VALUE: begin
        kind     = KIND_VALUE;
        rem_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_TRAIL;
        end
      end
      default: begin
        kind = KIND_TRAIL;
      end
    endcase

    result.byte_kind    = kind;
    result.byte_out     = word.msg_byte;
    result.message_done = word.msg_last;
    result.message_ok   = word.msg_last && (phase_next == PH_TRAIL);

    // The last byte always drops the parser back to the header phase.
    if (word.msg_last) begin
      phase_next = PH_HEADER;
      count_next = '0;
      acc_next   = '0;
      rem_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_REQUEST;
    end else if (cfg_write) begin
      format_mode <= mode_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      count <= '0;
      acc   <= '0;
      rem   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      count <= count_next;
      acc   <= acc_next;
      rem   <= rem_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && word.msg_last |=> phase == PH_HEADER && rem == '0 && count == '0)
    else $error("parser did not return to the header phase after a last byte");

  a_data_phase_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_KEY || phase == PH_VALUE) |-> rem != '0)
    else $error("data phase entered with no bytes remaining");

  a_header_count_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> count == '0 && acc == '0)
    else $error("length collection state not clear in the header phase");

endmodule

// ----- sv/lpmd_out_stage.sv -----
// Result register stage of the deframer.
// Holds one tagged word until the downstream side takes it.
// Depends on lpmd_pkg.
module lpmd_out_stage import lpmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_word_t load_word,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      valid;
  out_word_t word;

  assign room      = !valid || !out_stall;
  assign out_valid = valid;
  assign out_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      word <= load_word;
    end
  end

endmodule

// ----- sv/length_prefixed_message_deframer.sv -----
// Top level of the length-prefixed message deframer.
// Instantiates the input stage, the parser and the result stage; uses lpmd_pkg.
//
// The deframer takes one message byte per word, with a flag on the final byte,
// and returns one tagged word for every byte: header code, length field byte,
// key byte, value byte or trailing byte, with the byte itself passed through.
// A message is a header code byte, then in request format a big-endian 32-bit
// key length and the key bytes, then a big-endian 32-bit value length and the
// value bytes; in response format the key section is absent. On the final byte
// message_done is set and message_ok tells whether the value section was
// complete. Key and value bytes go out as they arrive, so a consumer that sees
// message_ok low must drop what it kept of that message. format_mode is taken
// when the header byte is parsed and should only be written while the block is
// idle. A byte is accepted every clock cycle in steady state while out_stall is
// low. Its result is presented on out_word once it has moved from the input
// register into the result register, and can be taken at the next edge.
// A result-side stall holds the result register; the input stalls only when
// both registers are full and the result side is stalling. The parse state is
// updated as each byte moves into the result register, which is what sets the
// one-byte-per-cycle rate.
module length_prefixed_message_deframer import lpmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      held_valid;
  in_word_t  held_word;
  logic      room;
  logic      fire;
  out_word_t result;

  // A held byte is parsed in the cycle it moves into the result register.
  assign fire = held_valid && room;

  lpmd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (fire)
  );

  lpmd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .word      (held_word),
    .result    (result)
  );

  lpmd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_word (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // A completed message is only ever reported on its final byte.
  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.message_ok |-> out_word.message_done)
    else $error("message_ok raised without message_done");

endmodule
